FILE: hdl/hgm_pkg.sv
// heightfield to grid mesh: shared types, constants and codes
// used by every module of the block; depends on nothing

package hgm_pkg;

	// sizes of the grid and of the fixed point formats
	localparam int MAX_SIDE   = 4096;
	localparam int SIDE_W     = 12;
	localparam int SIZE_W     = 13;
	localparam int LOD_W      = 4;
	localparam int LOD_MAX    = 12;
	localparam int FRAC_BITS  = 16;
	localparam int SAMPLE_W   = 16;
	localparam int SCALE_W    = 24;
	localparam int POS_W      = 40;
	localparam int TEX_W      = FRAC_BITS + 1;
	localparam int IDX_W      = 24;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int MUL_STEPS  = 5;
	localparam int MUL_CNT_W  = 3;

	// register reset values
	localparam logic [SIZE_W-1:0]  RST_FIELD_WIDTH  = 13'd4096;
	localparam logic [SIZE_W-1:0]  RST_FIELD_HEIGHT = 13'd4096;
	localparam logic [LOD_W-1:0]   RST_LOD_LEVEL    = 4'd0;
	localparam logic [SCALE_W-1:0] RST_SCALE_X      = 24'd65536;
	localparam logic [SCALE_W-1:0] RST_SCALE_Y      = 24'd6553600;
	localparam logic [SCALE_W-1:0] RST_SCALE_Z      = 24'd65536;
	localparam logic               RST_CENTER_MESH  = 1'b1;
	localparam logic               RST_FLIP_Z       = 1'b0;

	// record kinds
	localparam logic KIND_VERTEX   = 1'b0;
	localparam logic KIND_TRIANGLE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CR_FIELD_WIDTH  = 3'd0,
		CR_FIELD_HEIGHT = 3'd1,
		CR_LOD_LEVEL    = 3'd2,
		CR_SCALE_X      = 3'd3,
		CR_SCALE_Y      = 3'd4,
		CR_SCALE_Z      = 3'd5,
		CR_CENTER_MESH  = 3'd6,
		CR_FLIP_Z       = 3'd7
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WORK,
		ST_VERT,
		ST_TRI0,
		ST_TRI1
	} ctrl_state_t;

	// multiplier steps, issued in this order
	typedef enum logic [MUL_CNT_W-1:0] {
		MS_OFFX = 3'd0,
		MS_PX   = 3'd1,
		MS_PY   = 3'd2,
		MS_OFFZ = 3'd3,
		MS_PZ   = 3'd4
	} mul_sel_t;

	typedef enum logic [1:0] {
		LD_VERT,
		LD_TRI0,
		LD_TRI1
	} load_sel_t;

	// clamped and derived configuration
	typedef struct packed {
		logic [SIZE_W-1:0]  width;
		logic [SIZE_W-1:0]  height;
		logic [LOD_W-1:0]   lod;
		logic [SIDE_W-1:0]  mesh_wm1;
		logic [SIDE_W-1:0]  mesh_hm1;
		logic [SCALE_W-1:0] scale_x;
		logic [SCALE_W-1:0] scale_y;
		logic [SCALE_W-1:0] scale_z;
		logic               center;
		logic               flip;
	} cfg_t;

	typedef struct packed {
		logic      accept;
		logic      div_start;
		logic      mul_go;
		mul_sel_t  mul_sel;
		logic      load;
		load_sel_t load_sel;
	} ctrl_cmd_t;

	typedef struct packed {
		logic kept;
		logic quad;
		logic div_done;
		logic out_free;
	} dp_status_t;

endpackage

FILE: hdl/hgm_regs.sv
// configuration registers with clamping of sizes and lod and the mesh extents
// depends on hgm_pkg

module hgm_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [hgm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hgm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output hgm_pkg::cfg_t                    cfg
);

	logic [hgm_pkg::SIZE_W-1:0]  field_width_q;
	logic [hgm_pkg::SIZE_W-1:0]  field_height_q;
	logic [hgm_pkg::LOD_W-1:0]   lod_level_q;
	logic [hgm_pkg::SCALE_W-1:0] scale_x_q;
	logic [hgm_pkg::SCALE_W-1:0] scale_y_q;
	logic [hgm_pkg::SCALE_W-1:0] scale_z_q;
	logic                        center_mesh_q;
	logic                        flip_z_q;

	logic [hgm_pkg::SIZE_W-1:0]  width_c;
	logic [hgm_pkg::SIZE_W-1:0]  height_c;
	logic [hgm_pkg::LOD_W-1:0]   lod_c;
	logic [hgm_pkg::SIZE_W-1:0]  wm1;
	logic [hgm_pkg::SIZE_W-1:0]  hm1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_width_q  <= hgm_pkg::RST_FIELD_WIDTH;
			field_height_q <= hgm_pkg::RST_FIELD_HEIGHT;
			lod_level_q    <= hgm_pkg::RST_LOD_LEVEL;
			scale_x_q      <= hgm_pkg::RST_SCALE_X;
			scale_y_q      <= hgm_pkg::RST_SCALE_Y;
			scale_z_q      <= hgm_pkg::RST_SCALE_Z;
			center_mesh_q  <= hgm_pkg::RST_CENTER_MESH;
			flip_z_q       <= hgm_pkg::RST_FLIP_Z;
		end else if (cfg_write) begin
			case (hgm_pkg::cfg_reg_t'(cfg_index))
				hgm_pkg::CR_FIELD_WIDTH:  field_width_q  <= cfg_data[hgm_pkg::SIZE_W-1:0];
				hgm_pkg::CR_FIELD_HEIGHT: field_height_q <= cfg_data[hgm_pkg::SIZE_W-1:0];
				hgm_pkg::CR_LOD_LEVEL:    lod_level_q    <= cfg_data[hgm_pkg::LOD_W-1:0];
				hgm_pkg::CR_SCALE_X:      scale_x_q      <= cfg_data[hgm_pkg::SCALE_W-1:0];
				hgm_pkg::CR_SCALE_Y:      scale_y_q      <= cfg_data[hgm_pkg::SCALE_W-1:0];
				hgm_pkg::CR_SCALE_Z:      scale_z_q      <= cfg_data[hgm_pkg::SCALE_W-1:0];
				hgm_pkg::CR_CENTER_MESH:  center_mesh_q  <= cfg_data[0];
				hgm_pkg::CR_FLIP_Z:       flip_z_q       <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// zero size acts as one, oversize as the maximum side
	always_comb begin
		if (field_width_q == '0)
			width_c = hgm_pkg::SIZE_W'(1);
		else if (field_width_q > hgm_pkg::SIZE_W'(hgm_pkg::MAX_SIDE))
			width_c = hgm_pkg::SIZE_W'(hgm_pkg::MAX_SIDE);
		else
			width_c = field_width_q;

		if (field_height_q == '0)
			height_c = hgm_pkg::SIZE_W'(1);
		else if (field_height_q > hgm_pkg::SIZE_W'(hgm_pkg::MAX_SIDE))
			height_c = hgm_pkg::SIZE_W'(hgm_pkg::MAX_SIDE);
		else
			height_c = field_height_q;

		if (lod_level_q > hgm_pkg::LOD_W'(hgm_pkg::LOD_MAX))
			lod_c = hgm_pkg::LOD_W'(hgm_pkg::LOD_MAX);
		else
			lod_c = lod_level_q;
	end

	// mesh side minus one is the last decimated index
	assign wm1 = width_c - hgm_pkg::SIZE_W'(1);
	assign hm1 = height_c - hgm_pkg::SIZE_W'(1);

	assign cfg.width    = width_c;
	assign cfg.height   = height_c;
	assign cfg.lod      = lod_c;
	assign cfg.mesh_wm1 = wm1[hgm_pkg::SIDE_W-1:0] >> lod_c;
	assign cfg.mesh_hm1 = hm1[hgm_pkg::SIDE_W-1:0] >> lod_c;
	assign cfg.scale_x  = scale_x_q;
	assign cfg.scale_y  = scale_y_q;
	assign cfg.scale_z  = scale_z_q;
	assign cfg.center   = center_mesh_q;
	assign cfg.flip     = flip_z_q;

endmodule

FILE: hdl/hgm_div.sv
// restoring divider, one quotient bit per cycle: floor(numer * 2^FRAC_BITS / denom)
// for numer <= denom; depends on hgm_pkg

module hgm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [hgm_pkg::SIDE_W-1:0]   numer,
	input  logic [hgm_pkg::SIDE_W-1:0]   denom,
	output logic                         done,
	output logic [hgm_pkg::TEX_W-1:0]    quot
);

	localparam int CNT_W = $clog2(hgm_pkg::TEX_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [hgm_pkg::SIDE_W-1:0]  num_q;
	logic [hgm_pkg::SIDE_W-1:0]  den_q;
	logic [hgm_pkg::SIDE_W-1:0]  rem_q;
	logic [hgm_pkg::TEX_W-1:0]   quot_q;

	logic [hgm_pkg::SIDE_W:0]    trial;
	logic [hgm_pkg::SIDE_W:0]    diff;
	logic                        qbit;

	// first step takes the integer part, later steps bring in zero bits
	always_comb begin
		if (cnt_q == '0)
			trial = {1'b0, num_q};
		else
			trial = {rem_q, 1'b0};
		diff = trial - {1'b0, den_q};
		qbit = (trial >= {1'b0, den_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(hgm_pkg::TEX_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numer;
			den_q <= denom;
		end else if (busy_q) begin
			if (qbit)
				rem_q <= diff[hgm_pkg::SIDE_W-1:0];
			else
				rem_q <= trial[hgm_pkg::SIDE_W-1:0];
			quot_q <= {quot_q[hgm_pkg::TEX_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

FILE: hdl/hgm_datapath.sv
// datapath: raster counters, shared multiplier with offset and sign stage,
// texture dividers and the result register; depends on hgm_pkg and hgm_div

module hgm_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hgm_pkg::cfg_t                 cfg,
	input  hgm_pkg::ctrl_cmd_t            cmd,
	output hgm_pkg::dp_status_t           status,
	input  logic [hgm_pkg::SAMPLE_W-1:0]  height_sample,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          kind,
	output logic [hgm_pkg::POS_W-1:0]     pos_x,
	output logic [hgm_pkg::POS_W-1:0]     pos_y,
	output logic [hgm_pkg::POS_W-1:0]     pos_z,
	output logic [hgm_pkg::TEX_W-1:0]     tex_u,
	output logic [hgm_pkg::TEX_W-1:0]     tex_v,
	output logic [hgm_pkg::IDX_W-1:0]     corner_a,
	output logic [hgm_pkg::IDX_W-1:0]     corner_b,
	output logic [hgm_pkg::IDX_W-1:0]     corner_c,
	output logic                          last
);

	localparam int SW = hgm_pkg::SIDE_W;
	localparam int PW = hgm_pkg::POS_W;
	localparam int IW = hgm_pkg::IDX_W;

	// raster position and vertex count
	logic [SW-1:0] col_q;
	logic [SW-1:0] row_q;
	logic [IW-1:0] vc_q;

	// captured request
	logic [hgm_pkg::SAMPLE_W-1:0] s_q;
	logic [SW-1:0]                x_q;
	logic [SW-1:0]                z_q;
	logic [IW-1:0]                vi_q;
	logic                         kept_q;
	logic                         quad_q;

	logic [SW-1:0]     col_e;
	logic [SW-1:0]     row_e;
	logic [SW-1:0]     step_mask;
	logic [SW-1:0]     x_c;
	logic [SW-1:0]     z_c;
	logic              kept_c;
	logic [SW:0]       col_inc;
	logic [SW:0]       row_inc;
	logic [IW-1:0]     vc_inc;

	// multiplier stage
	logic [hgm_pkg::SAMPLE_W-1:0]  mul_a;
	logic [hgm_pkg::SCALE_W-1:0]   mul_b;
	logic [PW-1:0]                 prod;
	logic [PW-1:0]                 prod_s1;
	hgm_pkg::mul_sel_t             sel_s1;
	logic                          pvld_s1;

	logic [PW:0]   half_sum;
	logic [PW-1:0] half;
	logic [PW-1:0] pz_sum;
	logic [PW-1:0] offx_q;
	logic [PW-1:0] offz_q;
	logic [PW-1:0] px_q;
	logic [PW-1:0] py_q;
	logic [PW-1:0] pz_q;

	// texture dividers
	logic                        u_done;
	logic                        v_done;
	logic [hgm_pkg::TEX_W-1:0]   u_quot;
	logic [hgm_pkg::TEX_W-1:0]   v_quot;
	logic [hgm_pkg::TEX_W-1:0]   u_val;
	logic [hgm_pkg::TEX_W-1:0]   v_val;

	// triangle corners
	logic [IW-1:0] mesh_w;
	logic [IW-1:0] i0;
	logic [IW-1:0] i1;
	logic [IW-1:0] i2;

	// result register
	logic                        out_valid_q;
	logic                        kind_q;
	logic [PW-1:0]               pos_x_q;
	logic [PW-1:0]               pos_y_q;
	logic [PW-1:0]               pos_z_q;
	logic [hgm_pkg::TEX_W-1:0]   tex_u_q;
	logic [hgm_pkg::TEX_W-1:0]   tex_v_q;
	logic [IW-1:0]               corner_a_q;
	logic [IW-1:0]               corner_b_q;
	logic [IW-1:0]               corner_c_q;
	logic                        last_q;
	logic                        out_take;

	// wrap positions beyond the current size, then test decimation
	always_comb begin
		col_e     = ({1'b0, col_q} >= cfg.width)  ? '0 : col_q;
		row_e     = ({1'b0, row_q} >= cfg.height) ? '0 : row_q;
		step_mask = ~({SW{1'b1}} << cfg.lod);
		x_c       = col_e >> cfg.lod;
		z_c       = row_e >> cfg.lod;
		kept_c    = ((col_e & step_mask) == '0) && ((row_e & step_mask) == '0);
		col_inc   = {1'b0, col_e} + (SW+1)'(1);
		row_inc   = {1'b0, row_e} + (SW+1)'(1);
		vc_inc    = kept_c ? (vc_q + IW'(1)) : vc_q;
	end

	// raster counters advance on every accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			vc_q  <= '0;
		end else if (cmd.accept) begin
			if (col_inc >= cfg.width) begin
				col_q <= '0;
				if (row_inc >= cfg.height) begin
					row_q <= '0;
					vc_q  <= '0;
				end else begin
					row_q <= row_inc[SW-1:0];
					vc_q  <= vc_inc;
				end
			end else begin
				col_q <= col_inc[SW-1:0];
				// a row beyond a shrunk field is kept wrapped
				row_q <= row_e;
				vc_q  <= vc_inc;
			end
		end
	end

	// capture of the accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= 1'b0;
		end else if (cmd.accept) begin
			kept_q <= kept_c;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			s_q    <= height_sample;
			x_q    <= x_c;
			z_q    <= z_c;
			vi_q   <= vc_q;
			quad_q <= (x_c != '0) && (z_c != '0);
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			hgm_pkg::MS_OFFX: begin
				mul_a = hgm_pkg::SAMPLE_W'(cfg.mesh_wm1);
				mul_b = cfg.scale_x;
			end
			hgm_pkg::MS_PX: begin
				mul_a = hgm_pkg::SAMPLE_W'(x_q);
				mul_b = cfg.scale_x;
			end
			hgm_pkg::MS_PY: begin
				mul_a = s_q;
				mul_b = cfg.scale_y;
			end
			hgm_pkg::MS_OFFZ: begin
				mul_a = hgm_pkg::SAMPLE_W'(cfg.mesh_hm1);
				mul_b = cfg.scale_z;
			end
			hgm_pkg::MS_PZ: begin
				mul_a = hgm_pkg::SAMPLE_W'(z_q);
				mul_b = cfg.scale_z;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pvld_s1 <= 1'b0;
		else
			pvld_s1 <= cmd.mul_go;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_go) begin
			prod_s1 <= prod;
			sel_s1  <= cmd.mul_sel;
		end
	end

	// ceil of half the extent, and the z sum before the optional negation
	assign half_sum = {1'b0, prod_s1} + (PW+1)'(1);
	assign half     = half_sum[PW:1];
	assign pz_sum   = prod_s1 + offz_q;

	// offset, sum and sign stage
	always_ff @(posedge clk) begin
		if (pvld_s1) begin
			case (sel_s1)
				hgm_pkg::MS_OFFX: offx_q <= cfg.center ? (PW'(0) - half) : '0;
				hgm_pkg::MS_PX:   px_q   <= prod_s1 + offx_q;
				hgm_pkg::MS_PY:   py_q   <= prod_s1 >> hgm_pkg::SAMPLE_W;
				hgm_pkg::MS_OFFZ: offz_q <= cfg.center ? (PW'(0) - half) : '0;
				hgm_pkg::MS_PZ:   pz_q   <= cfg.flip ? (PW'(0) - pz_sum) : pz_sum;
				default: ;
			endcase
		end
	end

	// texture coordinate dividers
	hgm_div u_div_u (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (x_q),
		.denom  (cfg.mesh_wm1),
		.done   (u_done),
		.quot   (u_quot)
	);

	hgm_div u_div_v (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (z_q),
		.denom  (cfg.mesh_hm1),
		.done   (v_done),
		.quot   (v_quot)
	);

	// a mesh side of one gives a zero coordinate
	assign u_val = (cfg.mesh_wm1 == '0) ? '0 : u_quot;
	assign v_val = (cfg.mesh_hm1 == '0) ? '0 : v_quot;

	// quad corners, indices wrap modulo the index width
	assign mesh_w = IW'(cfg.mesh_wm1) + IW'(1);
	assign i2     = vi_q - IW'(1);
	assign i1     = vi_q - mesh_w;
	assign i0     = i1 - IW'(1);

	// result register
	assign out_take = out_valid_q && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load)
			out_valid_q <= 1'b1;
		else if (out_take)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.load_sel)
				hgm_pkg::LD_VERT: begin
					kind_q     <= hgm_pkg::KIND_VERTEX;
					pos_x_q    <= px_q;
					pos_y_q    <= py_q;
					pos_z_q    <= pz_q;
					tex_u_q    <= u_val;
					tex_v_q    <= v_val;
					corner_a_q <= '0;
					corner_b_q <= '0;
					corner_c_q <= '0;
					last_q     <= !quad_q;
				end
				hgm_pkg::LD_TRI0: begin
					kind_q     <= hgm_pkg::KIND_TRIANGLE;
					pos_x_q    <= '0;
					pos_y_q    <= '0;
					pos_z_q    <= '0;
					tex_u_q    <= '0;
					tex_v_q    <= '0;
					corner_a_q <= i0;
					corner_b_q <= i1;
					corner_c_q <= i2;
					last_q     <= 1'b0;
				end
				hgm_pkg::LD_TRI1: begin
					kind_q     <= hgm_pkg::KIND_TRIANGLE;
					pos_x_q    <= '0;
					pos_y_q    <= '0;
					pos_z_q    <= '0;
					tex_u_q    <= '0;
					tex_v_q    <= '0;
					corner_a_q <= i1;
					corner_b_q <= vi_q;
					corner_c_q <= i2;
					last_q     <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// status to the controller
	assign status.kept     = kept_q;
	assign status.quad     = quad_q;
	assign status.div_done = u_done && v_done;
	assign status.out_free = !out_valid_q || out_take;

	assign result_valid = out_valid_q;
	assign kind         = kind_q;
	assign pos_x        = pos_x_q;
	assign pos_y        = pos_y_q;
	assign pos_z        = pos_z_q;
	assign tex_u        = tex_u_q;
	assign tex_v        = tex_v_q;
	assign corner_a     = corner_a_q;
	assign corner_b     = corner_b_q;
	assign corner_c     = corner_c_q;
	assign last         = last_q;

endmodule

FILE: hdl/hgm_ctrl.sv
// controller: sequences acceptance, multiplier steps, dividers and result loads
// depends on hgm_pkg

module hgm_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  hgm_pkg::dp_status_t  status,
	output hgm_pkg::ctrl_cmd_t   cmd
);

	localparam int CW = hgm_pkg::MUL_CNT_W;

	hgm_pkg::ctrl_state_t state_q;
	hgm_pkg::ctrl_state_t state_d;
	logic [CW-1:0]        mul_cnt_q;
	logic [CW-1:0]        mul_cnt_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= hgm_pkg::ST_IDLE;
			mul_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			mul_cnt_q <= mul_cnt_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d      = state_q;
		mul_cnt_d    = mul_cnt_q;
		sample_stall = 1'b1;
		cmd          = '0;
		cmd.mul_sel  = hgm_pkg::mul_sel_t'(mul_cnt_q);
		cmd.load_sel = hgm_pkg::LD_VERT;
		case (state_q)
			hgm_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.accept = 1'b1;
					state_d    = hgm_pkg::ST_CHECK;
				end
			end
			hgm_pkg::ST_CHECK: begin
				mul_cnt_d = '0;
				if (status.kept) begin
					cmd.div_start = 1'b1;
					state_d       = hgm_pkg::ST_WORK;
				end else begin
					state_d = hgm_pkg::ST_IDLE;
				end
			end
			hgm_pkg::ST_WORK: begin
				// one extra count lets the last product clear the sum stage
				if (mul_cnt_q < CW'(hgm_pkg::MUL_STEPS))
					cmd.mul_go = 1'b1;
				if (mul_cnt_q <= CW'(hgm_pkg::MUL_STEPS))
					mul_cnt_d = mul_cnt_q + CW'(1);
				else if (status.div_done)
					state_d = hgm_pkg::ST_VERT;
			end
			hgm_pkg::ST_VERT: begin
				if (status.out_free) begin
					cmd.load     = 1'b1;
					cmd.load_sel = hgm_pkg::LD_VERT;
					state_d      = status.quad ? hgm_pkg::ST_TRI0 : hgm_pkg::ST_IDLE;
				end
			end
			hgm_pkg::ST_TRI0: begin
				if (status.out_free) begin
					cmd.load     = 1'b1;
					cmd.load_sel = hgm_pkg::LD_TRI0;
					state_d      = hgm_pkg::ST_TRI1;
				end
			end
			hgm_pkg::ST_TRI1: begin
				if (status.out_free) begin
					cmd.load     = 1'b1;
					cmd.load_sel = hgm_pkg::LD_TRI1;
					state_d      = hgm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = hgm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: hdl/heightfield_to_grid_mesh_top.sv
// Heightfield to grid mesh tessellator. Samples arrive in raster order, one
// request per sample; every sample on the decimation grid becomes a vertex
// record, followed by the two triangle records of the quad it closes, if any.
// A new sample is taken only when the block is done with the last one, and
// records leave at one per cycle while the output is not stalled. The pace is
// set by the 17-step restoring dividers that produce the texture coordinates,
// while the shared multiplier finishes its five products in their shadow.
// Configuration is written through a plain write port.
// Holds the top level; depends on hgm_pkg, hgm_regs, hgm_ctrl, hgm_datapath.

module heightfield_to_grid_mesh_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [hgm_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hgm_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic [hgm_pkg::SAMPLE_W-1:0]         height_sample,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic                                 kind,
	output logic signed [hgm_pkg::POS_W-1:0]     pos_x,
	output logic signed [hgm_pkg::POS_W-1:0]     pos_y,
	output logic signed [hgm_pkg::POS_W-1:0]     pos_z,
	output logic [hgm_pkg::TEX_W-1:0]            tex_u,
	output logic [hgm_pkg::TEX_W-1:0]            tex_v,
	output logic [hgm_pkg::IDX_W-1:0]            corner_a,
	output logic [hgm_pkg::IDX_W-1:0]            corner_b,
	output logic [hgm_pkg::IDX_W-1:0]            corner_c,
	output logic                                 last
);

	hgm_pkg::cfg_t                 cfg;
	hgm_pkg::ctrl_cmd_t            cmd;
	hgm_pkg::dp_status_t           status;
	logic [hgm_pkg::POS_W-1:0]     pos_x_u;
	logic [hgm_pkg::POS_W-1:0]     pos_y_u;
	logic [hgm_pkg::POS_W-1:0]     pos_z_u;

	// configuration registers
	hgm_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// sequencer
	hgm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// arithmetic and result register
	hgm_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.status        (status),
		.height_sample (height_sample),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.pos_x         (pos_x_u),
		.pos_y         (pos_y_u),
		.pos_z         (pos_z_u),
		.tex_u         (tex_u),
		.tex_v         (tex_v),
		.corner_a      (corner_a),
		.corner_b      (corner_b),
		.corner_c      (corner_c),
		.last          (last)
	);

	// positions are two's complement on the ports
	assign pos_x = $signed(pos_x_u);
	assign pos_y = $signed(pos_y_u);
	assign pos_z = $signed(pos_z_u);

endmodule

FILE: tb/sv/heightfield_to_grid_mesh_top_tb.sv
// self-checking testbench for the heightfield to grid mesh tessellator
// drives raster samples and register writes, predicts vertex and triangle records
// depends on hgm_pkg and heightfield_to_grid_mesh_top
`timescale 1ns / 100ps

module heightfield_to_grid_mesh_top_tb;
	import hgm_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_LIMIT   = 20000;
	localparam int ITEM_COUNT    = 310;
	localparam int LONG_STALL    = 300;

	// one output record as the block presents it
	typedef struct packed {
		logic                kind;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [POS_W-1:0]    pos_z;
		logic [TEX_W-1:0]    tex_u;
		logic [TEX_W-1:0]    tex_v;
		logic [IDX_W-1:0]    corner_a;
		logic [IDX_W-1:0]    corner_b;
		logic [IDX_W-1:0]    corner_c;
		logic                last;
	} mesh_rec_t;

	// tessellation tracker: own copy of registers and raster position
	class mesh_record_board;
		logic [SIZE_W-1:0]  fw, fh;
		logic [LOD_W-1:0]   lod_r;
		logic [SCALE_W-1:0] sx, sy, sz;
		logic               ctr, flp;
		int unsigned        col, row;
		logic [IDX_W-1:0]   vcount;
		mesh_rec_t          records_due[$];
		int                 errors;
		int                 checked;

		function new();
			fw = RST_FIELD_WIDTH;
			fh = RST_FIELD_HEIGHT;
			lod_r = RST_LOD_LEVEL;
			sx = RST_SCALE_X;
			sy = RST_SCALE_Y;
			sz = RST_SCALE_Z;
			ctr = RST_CENTER_MESH;
			flp = RST_FLIP_Z;
			col = 0;
			row = 0;
			vcount = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
			case (r)
				CR_FIELD_WIDTH:  fw = d[SIZE_W-1:0];
				CR_FIELD_HEIGHT: fh = d[SIZE_W-1:0];
				CR_LOD_LEVEL:    lod_r = d[LOD_W-1:0];
				CR_SCALE_X:      sx = d;
				CR_SCALE_Y:      sy = d;
				CR_SCALE_Z:      sz = d;
				CR_CENTER_MESH:  ctr = d[0];
				CR_FLIP_Z:       flp = d[0];
				default: ;
			endcase
		endfunction

		function int unsigned clamp_side(logic [SIZE_W-1:0] v);
			if (v < 1) return 1;
			if (v > MAX_SIDE) return MAX_SIDE;
			return 32'(v);
		endfunction

		// minus half the extent, rounded up, when centering is on
		function logic [63:0] centre_off(int unsigned side, logic [SCALE_W-1:0] sc);
			logic [63:0] a;
			a = 64'(side - 1) * 64'(sc);
			return ctr ? (64'd0 - ((a + 64'd1) >> 1)) : 64'd0;
		endfunction

		function logic [TEX_W-1:0] tex_coord(int unsigned i, int unsigned side);
			if (side <= 1) return '0;
			return TEX_W'((64'(i) << FRAC_BITS) / 64'(side - 1));
		endfunction

		// queues the records one accepted sample causes, returns their count
		function int tessellate_sample(logic [SAMPLE_W-1:0] s);
			int unsigned w, h, lod, stepm, mw, mh, x, z;
			logic [IDX_W-1:0] vi;
			logic [63:0] px, py, pz;
			mesh_rec_t v, t;
			int n;
			w = clamp_side(fw);
			h = clamp_side(fh);
			lod = (lod_r > LOD_MAX) ? LOD_MAX : 32'(lod_r);
			stepm = (1 << lod) - 1;
			mw = ((w - 1) >> lod) + 1;
			mh = ((h - 1) >> lod) + 1;
			n = 0;
			// position beyond a shrunk field wraps at once
			if (col >= w) col = 0;
			if (row >= h) row = 0;
			if ((col & stepm) == 0 && (row & stepm) == 0) begin
				x = col >> lod;
				z = row >> lod;
				vi = vcount;
				px = 64'(x) * 64'(sx) + centre_off(mw, sx);
				py = (64'(s) * 64'(sy)) >> FRAC_BITS;
				pz = 64'(z) * 64'(sz) + centre_off(mh, sz);
				if (flp) pz = 64'd0 - pz;
				v = '0;
				v.kind = KIND_VERTEX;
				v.pos_x = px[POS_W-1:0];
				v.pos_y = py[POS_W-1:0];
				v.pos_z = pz[POS_W-1:0];
				v.tex_u = tex_coord(x, mw);
				v.tex_v = tex_coord(z, mh);
				v.last = !(x > 0 && z > 0);
				records_due.push_back(v);
				n = 1;
				// quad closed by this vertex
				if (x > 0 && z > 0) begin
					t = '0;
					t.kind = KIND_TRIANGLE;
					t.corner_a = vi - IDX_W'(mw) - 24'd1;
					t.corner_b = vi - IDX_W'(mw);
					t.corner_c = vi - 24'd1;
					records_due.push_back(t);
					t.corner_a = vi - IDX_W'(mw);
					t.corner_b = vi;
					t.corner_c = vi - 24'd1;
					t.last = 1'b1;
					records_due.push_back(t);
					n = 3;
				end
				vcount = vi + 24'd1;
			end
			// advance raster position, new field after the last sample
			col++;
			if (col >= w) begin
				col = 0;
				row++;
				if (row >= h) begin
					row = 0;
					vcount = '0;
				end
			end
			return n;
		endfunction

		function void match_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				errors++;
			end
		endfunction

		function void compare_record(mesh_rec_t got);
			mesh_rec_t want;
			if (records_due.size() == 0) begin
				$error("record with none due: kind %0d", got.kind);
				errors++;
				return;
			end
			want = records_due.pop_front();
			checked++;
			match_field("kind", 64'(want.kind), 64'(got.kind));
			match_field("pos_x", 64'($signed(want.pos_x)), 64'($signed(got.pos_x)));
			match_field("pos_y", 64'($signed(want.pos_y)), 64'($signed(got.pos_y)));
			match_field("pos_z", 64'($signed(want.pos_z)), 64'($signed(got.pos_z)));
			match_field("tex_u", 64'(want.tex_u), 64'(got.tex_u));
			match_field("tex_v", 64'(want.tex_v), 64'(got.tex_v));
			match_field("corner_a", 64'(want.corner_a), 64'(got.corner_a));
			match_field("corner_b", 64'(want.corner_b), 64'(got.corner_b));
			match_field("corner_c", 64'(want.corner_c), 64'(got.corner_c));
			match_field("last", 64'(want.last), 64'(got.last));
		endfunction
	endclass

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        sample_valid = 1'b0;
	logic                        sample_stall;
	logic [SAMPLE_W-1:0]         height_sample = '0;
	logic                        result_valid;
	logic                        result_stall = 1'b0;
	logic                        kind;
	logic signed [POS_W-1:0]     pos_x, pos_y, pos_z;
	logic [TEX_W-1:0]            tex_u, tex_v;
	logic [IDX_W-1:0]            corner_a, corner_b, corner_c;
	logic                        last;

	mesh_record_board mesh_board = new();
	int idle_max = 5;
	int long_hold = 0;
	int result_hold = 0;
	int cycles = 0;
	int samples_sent = 0;
	int samples_kept = 0;
	int settings_used = 0;

	heightfield_to_grid_mesh_top DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.sample_valid(sample_valid), .sample_stall(sample_stall),
		.height_sample(height_sample),
		.result_valid(result_valid), .result_stall(result_stall),
		.kind(kind), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.tex_u(tex_u), .tex_v(tex_v),
		.corner_a(corner_a), .corner_b(corner_b), .corner_c(corner_c),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles", cycles);
		$display("status: fail");
		$finish;
	end

	// result side: check at the rising edge, stall decisions at the falling edge
	initial begin
		mesh_rec_t got;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall) begin
				got.kind = kind;
				got.pos_x = pos_x;
				got.pos_y = pos_y;
				got.pos_z = pos_z;
				got.tex_u = tex_u;
				got.tex_v = tex_v;
				got.corner_a = corner_a;
				got.corner_b = corner_b;
				got.corner_c = corner_c;
				got.last = last;
				mesh_board.compare_record(got);
				result_hold = $urandom_range(0, idle_max);
			end
			@(negedge clk);
			if (long_hold > 0) begin
				result_stall = 1'b1;
				long_hold--;
			end else if (result_hold > 0) begin
				result_stall = 1'b1;
				result_hold--;
			end else begin
				result_stall = 1'b0;
			end
		end
	end

	// one sample request, returns at the edge that accepted it
	task automatic offer_sample(input logic [SAMPLE_W-1:0] s);
		int gap;
		gap = $urandom_range(0, idle_max);
		@(negedge clk);
		if (gap > 0) begin
			sample_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_valid = 1'b1;
		height_sample = s;
		forever begin
			@(posedge clk);
			if (!sample_stall) break;
		end
		samples_sent++;
		if (mesh_board.tessellate_sample(s) > 0) samples_kept++;
	endtask

	// sender pauses until every due record is back, then lets the block settle
	task automatic wait_drained();
		int n;
		n = 0;
		@(negedge clk);
		sample_valid = 1'b0;
		while (mesh_board.records_due.size() > 0 && n < DRAIN_LIMIT) begin
			@(negedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] d);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = r;
		cfg_data = d;
		@(posedge clk);
		mesh_board.write_reg(r, d);
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	task automatic apply_setting(input logic [CFG_DATA_W-1:0] w, h, lod,
			sxv, syv, szv, ctr, flp);
		write_reg(CR_FIELD_WIDTH, w);
		write_reg(CR_FIELD_HEIGHT, h);
		write_reg(CR_LOD_LEVEL, lod);
		write_reg(CR_SCALE_X, sxv);
		write_reg(CR_SCALE_Y, syv);
		write_reg(CR_SCALE_Z, szv);
		write_reg(CR_CENTER_MESH, ctr);
		write_reg(CR_FLIP_Z, flp);
		settings_used++;
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_size(int unsigned typical);
		case ($urandom_range(0, 15))
			0: return 24'd0;
			1: return 24'd4096;
			2: return 24'd8191;
			3: return CFG_DATA_W'($urandom_range(0, 8191));
			default: return CFG_DATA_W'($urandom_range(1, typical));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_scale();
		case ($urandom_range(0, 7))
			0: return 24'd0;
			1: return 24'hFFFFFF;
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	initial begin
		int phase;
		int target;
		int sent_here;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings, first row of a full size field
		offer_sample(16'h0000);
		offer_sample(16'hFFFF);
		offer_sample(16'h8001);
		wait_drained();

		// maximum scales, centered and flipped, wraps the column mid-field
		apply_setting(24'd3, 24'd3, 24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd1, 24'd1);
		for (int i = 0; i < 9; i++)
			offer_sample((i % 2 == 0) ? 16'hFFFF : 16'h0000);
		wait_drained();

		// zero x and z scales, decimation with discarded samples
		apply_setting(24'd2, 24'd3, 24'd1, 24'd0, 24'd1, 24'd0, 24'd0, 24'd0);
		for (int i = 0; i < 6; i++) offer_sample(SAMPLE_W'($urandom));
		wait_drained();

		// sizes out of range and lod above the limit
		apply_setting(24'd0, 24'd8191, 24'd15, 24'h123456, 24'h00FFFF, 24'h800000,
			24'd1, 24'd1);
		for (int i = 0; i < 3; i++) offer_sample(SAMPLE_W'($urandom));
		wait_drained();
		apply_setting(24'd8191, 24'd1, 24'd12, 24'h010000, 24'hABCDEF, 24'h0000FF,
			24'd1, 24'd0);
		offer_sample(16'hFFFF);
		offer_sample(16'h0000);
		wait_drained();

		// random settings, mostly small fields at low lod, a few samples each
		phase = 0;
		while (samples_sent < ITEM_COUNT) begin
			apply_setting(pick_size(9), pick_size(6),
				CFG_DATA_W'(($urandom_range(0, 7) < 2) ? $urandom_range(3, 15) :
					$urandom_range(0, 2)),
				pick_scale(), pick_scale(), pick_scale(),
				CFG_DATA_W'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 1)));
			idle_max = ($urandom_range(0, 3) == 0) ? 0 : 5;
			target = $urandom_range(8, 40);
			sent_here = 0;
			if (phase == 3) begin
				// receiver holds off long while the sender keeps pushing
				idle_max = 0;
				offer_sample(pick_sample());
				sent_here++;
				long_hold = LONG_STALL;
			end
			while (sent_here < target && samples_sent < ITEM_COUNT) begin
				offer_sample(pick_sample());
				sent_here++;
			end
			wait_drained();
			idle_max = 5;
			phase++;
		end

		wait_drained();
		if (mesh_board.records_due.size() > 0) begin
			$error("%0d records still due at the end", mesh_board.records_due.size());
			mesh_board.errors++;
		end
		$display("sent %0d samples, %0d on the grid, over %0d register settings",
			samples_sent, samples_kept, settings_used);
		$display("checked %0d records with %0d mismatches", mesh_board.checked,
			mesh_board.errors);
		if (mesh_board.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
